// File: rtl/core/ed_pkg.sv
// Shared constants and controller/datapath interface types for the distance engine.
package ed_pkg;

  localparam int MAX_DIM_DEF = 256;   // default query store depth
  localparam int DIM_W       = 9;     // dim register width
  localparam int VAL_W       = 16;    // element width
  localparam int SQ_W        = 32;    // one squared difference
  localparam int ACC_W       = 40;    // sum of squares
  localparam int DIST_W      = 20;    // integer square root
  localparam int IDX_W       = 16;    // vector ordinal
  localparam int ROOT_W      = ACC_W + 1;
  localparam int ROOT_STEPS  = ACC_W / 2;
  localparam int RCNT_W      = $clog2(ROOT_STEPS + 1);
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // register index, taken from paddr above the byte lanes
  localparam logic REG_DIM = 1'b0;

  // input op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAND = 1'b1;

  typedef struct packed {
    logic load_we;     // write query element
    logic cand_take;   // latch candidate element, advance position
    logic sq_en;       // register squared difference
    logic acc_add;     // add squared difference into accumulator
    logic root_start;  // load root unit from accumulator sum
    logic root_step;   // one digit of the square root
    logic out_load;    // move result into output register
  } ed_cmd_t;

  typedef struct packed {
    logic last_elem;   // current candidate position is the last one
    logic root_done;   // all root digits done
  } ed_sts_t;

endpackage

// File: rtl/core/ed_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ed_ctrl.sv
// Sequencer for the distance engine: element flow, root iterations, result handoff.
module ed_ctrl
  import ed_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  logic    op,
  output logic    result_valid,
  input  logic    result_ready,
  output ed_cmd_t cmd,
  input  ed_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_ROOT,
    S_DONE
  } state_t;

  state_t state;
  logic   last_r;   // element in flight closes its vector
  logic   pend;     // squared difference waiting to be added
  logic   accept;
  logic   out_free;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.acc_add   = pend;
        cmd.load_we   = accept && (op == OP_LOAD);
        cmd.cand_take = accept && (op == OP_CAND);
      end
      S_MUL: begin
        cmd.sq_en = 1'b1;
      end
      S_ADD: begin
        cmd.acc_add    = 1'b1;
        cmd.root_start = 1'b1;
      end
      S_ROOT: begin
        cmd.root_step = !sts.root_done;
      end
      S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      last_r       <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (cmd.cand_take) begin
            last_r <= sts.last_elem;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (last_r) begin
            state <= S_ADD;
          end else begin
            pend  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_ADD: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sts.root_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/ed_datapath.sv
// Datapath: query store, squared difference, saturating sum, digit-serial root, result regs.
module ed_datapath
  import ed_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_clear,
  input  logic [DIM_W-1:0]        dim,
  input  logic signed [VAL_W-1:0] value,
  input  ed_cmd_t                 cmd,
  output ed_sts_t                 sts,
  output logic [DIST_W-1:0]       distance,
  output logic [ACC_W-1:0]        sum_squares,
  output logic [IDX_W-1:0]        vector_index
);

  localparam int PW = $clog2(MAX_DIM);
  localparam int DW = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;

  logic [DW-1:0]           dim_ext;
  logic [PW-1:0]           last_idx;
  logic [PW-1:0]           load_pos;
  logic [PW-1:0]           elem_pos;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] query;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W:0]          mag;
  logic [SQ_W-1:0]         sq_r;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W:0]          acc_sum;
  logic [ACC_W-1:0]        acc_sat;
  logic [IDX_W-1:0]        vcount;
  logic [ACC_W-1:0]        rn;
  logic [ROOT_W-1:0]       rres;
  logic [ROOT_W-1:0]       rbit;
  logic [ROOT_W-1:0]       rtry;
  logic [RCNT_W-1:0]       rcnt;

  ed_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_DIM)
  ) u_query (
    .clk  (clk),
    .we   (cmd.load_we),
    .waddr(load_pos),
    .wdata(value),
    .raddr(elem_pos),
    .rdata(query)
  );

  // effective length is dim clamped to 1..MAX_DIM
  always_comb begin
    dim_ext = DW'(dim);
    if (dim_ext == '0) begin
      last_idx = '0;
    end else if (dim_ext > DW'(MAX_DIM)) begin
      last_idx = PW'(MAX_DIM - 1);
    end else begin
      last_idx = PW'(dim_ext - DW'(1));
    end
  end

  assign diff    = {val_r[VAL_W-1], val_r} - {query[VAL_W-1], query};
  assign mag     = diff[VAL_W] ? (~diff + 1'b1) : diff;
  assign acc_sum = {1'b0, acc} + (ACC_W + 1)'(sq_r);
  assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
  assign rtry    = rres + rbit;

  assign sts.last_elem = (elem_pos == last_idx);
  assign sts.root_done = (rcnt == RCNT_W'(ROOT_STEPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      elem_pos <= '0;
      acc      <= '0;
      vcount   <= '0;
    end else begin
      if (cfg_clear) begin
        load_pos <= '0;
        elem_pos <= '0;
        acc      <= '0;
      end else begin
        if (cmd.load_we) begin
          load_pos <= (load_pos == last_idx) ? '0 : load_pos + 1'b1;
        end
        if (cmd.cand_take) begin
          elem_pos <= (elem_pos == last_idx) ? '0 : elem_pos + 1'b1;
        end
        if (cmd.acc_add) begin
          acc <= acc_sat;
        end else if (cmd.out_load) begin
          acc <= '0;
        end
      end
      if (cmd.out_load) begin
        vcount <= vcount + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_take) begin
      val_r <= value;
    end
    if (cmd.sq_en) begin
      sq_r <= SQ_W'(mag[VAL_W-1:0] * mag[VAL_W-1:0]);
    end
    if (cmd.root_start) begin
      rn   <= acc_sat;
      rres <= '0;
      rbit <= ROOT_W'(1) << (ACC_W - 2);
      rcnt <= '0;
    end else if (cmd.root_step) begin
      if ({1'b0, rn} >= rtry) begin
        rn   <= rn - rtry[ACC_W-1:0];
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
      rcnt <= rcnt + 1'b1;
    end
    if (cmd.out_load) begin
      distance     <= rres[DIST_W-1:0];
      sum_squares  <= acc;
      vector_index <= vcount;
    end
  end

endmodule

// File: rtl/core/euclidean_distance_engine.sv
// Top level of the Euclidean distance engine: config register, sequencer and datapath.
//
// Streams candidate vectors against one stored query vector and returns, per candidate,
// the exact sum of squared differences (40 bits, saturating), its floor square root and
// a 16-bit wrapping vector ordinal. A request with op=0 writes the next query element;
// op=1 brings the next candidate element. The vector length is register dim (address 0),
// clamped to 1..MAX_DIM; writing it restarts both the query load and the candidate in
// progress but keeps the vector ordinal. Timing: a query load leaves the sequencer idle,
// so the next request can follow; a candidate element passes the idle state (query RAM
// read) and then the multiply state (the 16x16 square), with the add overlapping the next
// request. The last element of a vector then goes through the add state, the root state
// (20 square root steps, two sum bits each) and the done state, which loads the result.
// The result register is separate, so accumulation of the next vector carries on while
// a result waits; the engine stalls only when a second result is ready before the first
// is taken. Query entries never written read back as don't-care.
module euclidean_distance_engine
  import ed_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // APB-style config port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  // request channel
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic                    op,
  input  logic signed [VAL_W-1:0] value,
  // result channel
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [DIST_W-1:0]       distance,
  output logic [ACC_W-1:0]        sum_squares,
  output logic [IDX_W-1:0]        vector_index
);

  logic [DIM_W-1:0] dim;
  logic             cfg_clear;
  ed_cmd_t          cmd;
  ed_sts_t          sts;

  // single register; byte lanes ignored in decode
  assign pready    = 1'b1;
  assign cfg_clear = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_DIM);
  assign prdata    = (paddr[PADDR_W-1] == REG_DIM) ? PDATA_W'(dim) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= DIM_W'(1);
    end else if (cfg_clear) begin
      dim <= pwdata[DIM_W-1:0];
    end
  end

  ed_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .op          (op),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  ed_datapath #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_clear   (cfg_clear),
    .dim         (dim),
    .value       (value),
    .cmd         (cmd),
    .sts         (sts),
    .distance    (distance),
    .sum_squares (sum_squares),
    .vector_index(vector_index)
  );

endmodule

// File: rtl/core/ed_checker.sv
// Port-level checks for the distance engine, bound to the top level.
module ed_checker
  import ed_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input logic [DIST_W-1:0] distance,
  input logic [ACC_W-1:0]  sum_squares,
  input logic [IDX_W-1:0]  vector_index
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(distance) &&
      $stable(sum_squares) && $stable(vector_index))
    else $error("stalled result changed");

  a_root: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((41'(distance) * 41'(distance)) <= 41'(sum_squares)) &&
      (((41'(distance) + 41'd1) * (41'(distance) + 41'd1)) > 41'(sum_squares)))
    else $error("distance is not floor root of sum");

  a_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready |=> !result_valid ||
      (vector_index == $past(vector_index) + 1'b1))
    else $error("vector index skipped");

endmodule

bind euclidean_distance_engine ed_checker u_ed_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .distance    (distance),
  .sum_squares (sum_squares),
  .vector_index(vector_index)
);
